// ===== hw/rtl/cps_pkg.sv =====
package cps_pkg;

   localparam int MAX_CORES   = 16;
   localparam int STORE_DEPTH = 16;

   localparam int CNT_W    = 5;
   localparam int ADDR_W   = $clog2(STORE_DEPTH);
   localparam int CTX_W    = 16;
   localparam int TIME_W   = 32;
   localparam int OVH_W    = 16;
   localparam int AREA_W   = 48;
   localparam int PROD_W   = CNT_W + TIME_W;
   localparam int CMD_W    = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [AREA_W-1:0] AREA_MAX  = {AREA_W{1'b1}};
   localparam logic [TIME_W-1:0] DELAY_MAX = {TIME_W{1'b1}};

   localparam logic [CMD_W-1:0] CMD_REQUEST = 2'd0;
   localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CLEAR   = 2'd2;
   localparam logic [CMD_W-1:0] CMD_NOP     = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_CORE_LIMIT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OVERHEAD   = 2'd1;

   typedef struct packed {
      logic [CTX_W-1:0]  context_id;
      logic [TIME_W-1:0] delay_ticks;
   } wait_entry_type;

   typedef struct packed {
      logic load_product;
      logic update;
      logic clear;
   } area_ctl_type;

endpackage

// ===== hw/rtl/cps_store.sv =====
module cps_store (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [cps_pkg::ADDR_W-1:0]    wr_addr,
   input  cps_pkg::wait_entry_type       wr_data,
   input  logic                          rd_en,
   input  logic [cps_pkg::ADDR_W-1:0]    rd_addr,
   output cps_pkg::wait_entry_type       rd_data
);

   cps_pkg::wait_entry_type mem_ff [cps_pkg::STORE_DEPTH];
   cps_pkg::wait_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/cps_area.sv =====
module cps_area (
   input  logic                          clock,
   input  logic                          reset,
   input  cps_pkg::area_ctl_type         ctl,
   input  logic [cps_pkg::CNT_W-1:0]     count,
   input  logic [cps_pkg::TIME_W-1:0]    elapsed,
   output logic [cps_pkg::AREA_W-1:0]    area_in
);

   logic [cps_pkg::PROD_W-1:0] product_ff;
   logic [cps_pkg::AREA_W-1:0] area_ff;
   logic [cps_pkg::AREA_W:0]   sum;
   logic                       saturate;

   always_ff @(posedge clock) begin
      if (ctl.load_product) begin
         product_ff <= cps_pkg::PROD_W'(count) * cps_pkg::PROD_W'(elapsed);
      end
   end

   always_comb begin
      sum      = (cps_pkg::AREA_W + 1)'(area_ff) + (cps_pkg::AREA_W + 1)'(product_ff);
      saturate = sum > {1'b0, cps_pkg::AREA_MAX};
      priority if (ctl.clear) begin
         area_in = '0;
      end else if (ctl.update) begin
         area_in = saturate ? cps_pkg::AREA_MAX : sum[cps_pkg::AREA_W-1:0];
      end else begin
         area_in = area_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         area_ff <= '0;
      end else begin
         area_ff <= area_in;
      end
   end

endmodule

// ===== hw/rtl/core_pool_scheduler.sv =====
// Core pool scheduler with a last-in-first-out store of waiting requests. Every accepted
// item produces exactly one result item. On acceptance the newest store entry is read and
// the elapsed time is formed; in S_MUL the busy and waiting counts are multiplied by that
// time; in S_DONE, once the result channel is free, the saturating area accumulation (on a
// release), the event delay sum, the store write (on a parked request) and the result
// register are updated. A new item is accepted only once the previous one has been placed
// in the result register, so it is not taken before the last one is through. The store
// needs no clearing pass; configuration writes are taken in any cycle.
module core_pool_scheduler (
   input  logic                               clock,
   input  logic                               reset,

   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [cps_pkg::CMD_W-1:0]          req_command,
   input  logic [cps_pkg::CTX_W-1:0]          req_context_id,
   input  logic [cps_pkg::TIME_W-1:0]         req_delay_ticks,
   input  logic                               req_core_continue,
   input  logic [cps_pkg::TIME_W-1:0]         req_now_ticks,

   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic                               rsp_event_valid,
   output logic [cps_pkg::CTX_W-1:0]          rsp_event_context,
   output logic [cps_pkg::TIME_W-1:0]         rsp_event_delay,
   output logic                               rsp_dropped,
   output logic [cps_pkg::CNT_W-1:0]          rsp_busy_count,
   output logic [cps_pkg::CNT_W-1:0]          rsp_waiting_count_out,
   output logic [cps_pkg::CNT_W-1:0]          rsp_max_waiting_out,
   output logic [cps_pkg::AREA_W-1:0]         rsp_busy_area_out,
   output logic [cps_pkg::AREA_W-1:0]         rsp_queue_area_out,

   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [cps_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [cps_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_MUL  = 2'd1;
   localparam logic [1:0] S_DONE = 2'd2;

   logic [1:0]                    state_ff, state_in;

   logic [cps_pkg::CNT_W-1:0]     core_limit_ff;
   logic [cps_pkg::OVH_W-1:0]     overhead_ff;

   logic [cps_pkg::CMD_W-1:0]     cmd_ff;
   logic [cps_pkg::CTX_W-1:0]     ctx_ff;
   logic [cps_pkg::TIME_W-1:0]    dly_ff;
   logic                          cont_ff;
   logic [cps_pkg::TIME_W-1:0]    now_ff;
   logic [cps_pkg::TIME_W-1:0]    elapsed_ff;

   logic [cps_pkg::CNT_W-1:0]     busy_ff, busy_in;
   logic [cps_pkg::CNT_W-1:0]     prev_busy_ff, prev_busy_in;
   logic [cps_pkg::CNT_W-1:0]     wait_ff, wait_in;
   logic [cps_pkg::CNT_W-1:0]     max_wait_ff, max_wait_in;
   logic [cps_pkg::TIME_W-1:0]    last_time_ff, last_time_in;

   logic                          rsp_valid_ff;
   logic                          ev_valid_ff, ev_valid_in;
   logic [cps_pkg::CTX_W-1:0]     ev_ctx_ff, ev_ctx_in;
   logic [cps_pkg::TIME_W-1:0]    ev_delay_ff, ev_delay_in;
   logic                          drop_ff, drop_in;
   logic [cps_pkg::AREA_W-1:0]    busy_area_ff, queue_area_ff;

   logic                          accept;
   logic                          commit;
   logic                          push;
   logic [cps_pkg::CNT_W-1:0]     limit;
   logic [cps_pkg::CNT_W-1:0]     wait_after_pop;
   logic [cps_pkg::TIME_W-1:0]    add_base;
   logic [cps_pkg::OVH_W-1:0]     add_ovh;
   logic [cps_pkg::TIME_W:0]      delay_sum;

   cps_pkg::wait_entry_type       wr_entry;
   cps_pkg::wait_entry_type       rd_entry;
   cps_pkg::area_ctl_type         area_ctl;
   logic [cps_pkg::AREA_W-1:0]    busy_area_in, queue_area_in;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign commit    = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_ready);
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         core_limit_ff <= cps_pkg::CNT_W'(1);
         overhead_ff   <= '0;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == cps_pkg::CSR_CORE_LIMIT) begin
            core_limit_ff <= csr_wdata[cps_pkg::CNT_W-1:0];
         end else if (csr_index == cps_pkg::CSR_OVERHEAD) begin
            overhead_ff <= csr_wdata[cps_pkg::OVH_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff     <= req_command;
         ctx_ff     <= req_context_id;
         dly_ff     <= req_delay_ticks;
         cont_ff    <= req_core_continue;
         now_ff     <= req_now_ticks;
         elapsed_ff <= (req_now_ticks >= last_time_ff) ? req_now_ticks - last_time_ff : '0;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            state_in = S_DONE;
         end
         S_DONE: begin
            if (commit) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign limit = (core_limit_ff > cps_pkg::CNT_W'(cps_pkg::MAX_CORES)) ?
                  cps_pkg::CNT_W'(cps_pkg::MAX_CORES) : core_limit_ff;

   assign wait_after_pop = (cmd_ff == cps_pkg::CMD_RELEASE && wait_ff != '0) ?
                           wait_ff - cps_pkg::CNT_W'(1) : wait_ff;

   always_comb begin
      busy_in      = busy_ff;
      prev_busy_in = prev_busy_ff;
      wait_in      = wait_ff;
      max_wait_in  = max_wait_ff;
      last_time_in = last_time_ff;
      ev_valid_in  = 1'b0;
      ev_ctx_in    = '0;
      add_base     = dly_ff;
      add_ovh      = '0;
      drop_in      = 1'b0;
      push         = 1'b0;
      unique case (cmd_ff)
         cps_pkg::CMD_REQUEST: begin
            if (cont_ff) begin
               ev_valid_in = 1'b1;
               ev_ctx_in   = ctx_ff;
            end else if (busy_ff < limit) begin
               busy_in     = busy_ff + cps_pkg::CNT_W'(1);
               ev_valid_in = 1'b1;
               ev_ctx_in   = ctx_ff;
               add_ovh     = overhead_ff;
            end else if (wait_ff < cps_pkg::CNT_W'(cps_pkg::STORE_DEPTH)) begin
               push    = 1'b1;
               wait_in = wait_ff + cps_pkg::CNT_W'(1);
               if (wait_in > max_wait_ff) begin
                  max_wait_in = wait_in;
               end
            end else begin
               drop_in = 1'b1;
            end
         end
         cps_pkg::CMD_RELEASE: begin
            if (wait_ff == '0) begin
               if (busy_ff != '0) begin
                  busy_in = busy_ff - cps_pkg::CNT_W'(1);
               end
            end else begin
               wait_in     = wait_after_pop;
               ev_valid_in = 1'b1;
               ev_ctx_in   = rd_entry.context_id;
               add_base    = rd_entry.delay_ticks;
               add_ovh     = overhead_ff;
            end
            prev_busy_in = busy_in;
            last_time_in = now_ff;
         end
         cps_pkg::CMD_CLEAR: begin
            busy_in      = '0;
            prev_busy_in = '0;
            wait_in      = '0;
            max_wait_in  = '0;
            last_time_in = '0;
         end
         cps_pkg::CMD_NOP: begin
         end
         default: begin
         end
      endcase
      delay_sum = (cps_pkg::TIME_W + 1)'(add_base) + (cps_pkg::TIME_W + 1)'(add_ovh);
      if (!ev_valid_in) begin
         ev_delay_in = '0;
      end else if (delay_sum[cps_pkg::TIME_W]) begin
         ev_delay_in = cps_pkg::DELAY_MAX;
      end else begin
         ev_delay_in = delay_sum[cps_pkg::TIME_W-1:0];
      end
   end

   assign wr_entry.context_id  = ctx_ff;
   assign wr_entry.delay_ticks = dly_ff;

   cps_store u_store (
      .clock   (clock),
      .wr_en   (commit && push),
      .wr_addr (wait_ff[cps_pkg::ADDR_W-1:0]),
      .wr_data (wr_entry),
      .rd_en   (accept),
      .rd_addr (cps_pkg::ADDR_W'(wait_ff - cps_pkg::CNT_W'(1))),
      .rd_data (rd_entry)
   );

   assign area_ctl.load_product = (state_ff == S_MUL);
   assign area_ctl.update       = commit && (cmd_ff == cps_pkg::CMD_RELEASE);
   assign area_ctl.clear        = commit && (cmd_ff == cps_pkg::CMD_CLEAR);

   cps_area u_busy_area (
      .clock   (clock),
      .reset   (reset),
      .ctl     (area_ctl),
      .count   (prev_busy_ff),
      .elapsed (elapsed_ff),
      .area_in (busy_area_in)
   );

   cps_area u_queue_area (
      .clock   (clock),
      .reset   (reset),
      .ctl     (area_ctl),
      .count   (wait_after_pop),
      .elapsed (elapsed_ff),
      .area_in (queue_area_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         busy_ff      <= '0;
         prev_busy_ff <= '0;
         wait_ff      <= '0;
         max_wait_ff  <= '0;
         last_time_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (commit) begin
            busy_ff      <= busy_in;
            prev_busy_ff <= prev_busy_in;
            wait_ff      <= wait_in;
            max_wait_ff  <= max_wait_in;
            last_time_ff <= last_time_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         ev_valid_ff   <= ev_valid_in;
         ev_ctx_ff     <= ev_ctx_in;
         ev_delay_ff   <= ev_delay_in;
         drop_ff       <= drop_in;
         busy_area_ff  <= busy_area_in;
         queue_area_ff <= queue_area_in;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_event_valid       = ev_valid_ff;
   assign rsp_event_context     = ev_ctx_ff;
   assign rsp_event_delay       = ev_delay_ff;
   assign rsp_dropped           = drop_ff;
   assign rsp_busy_count        = busy_ff;
   assign rsp_waiting_count_out = wait_ff;
   assign rsp_max_waiting_out   = max_wait_ff;
   assign rsp_busy_area_out     = busy_area_ff;
   assign rsp_queue_area_out    = queue_area_ff;

endmodule

// ===== hw/rtl/cps_checker.sv =====
module cps_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic                               rsp_event_valid,
   input logic [cps_pkg::CTX_W-1:0]          rsp_event_context,
   input logic [cps_pkg::TIME_W-1:0]         rsp_event_delay,
   input logic                               rsp_dropped,
   input logic [cps_pkg::CNT_W-1:0]          rsp_busy_count,
   input logic [cps_pkg::CNT_W-1:0]          rsp_waiting_count_out,
   input logic [cps_pkg::CNT_W-1:0]          rsp_max_waiting_out
);

   // A stalled result item keeps its event fields.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_event_delay)
         && $stable(rsp_event_context))
      else $error("result item changed while stalled");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_max_waiting_out >= rsp_waiting_count_out
         && rsp_waiting_count_out <= cps_pkg::CNT_W'(cps_pkg::STORE_DEPTH))
      else $error("waiting counts inconsistent");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_busy_count <= cps_pkg::CNT_W'(cps_pkg::MAX_CORES))
      else $error("busy count exceeds the pool size");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_event_valid |-> rsp_event_context == '0 && rsp_event_delay == '0)
      else $error("event fields set without an event");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_dropped |-> !rsp_event_valid
         && rsp_waiting_count_out == cps_pkg::CNT_W'(cps_pkg::STORE_DEPTH))
      else $error("drop reported while the store had room");

endmodule

bind core_pool_scheduler cps_checker u_cps_checker (
   .clock                 (clock),
   .reset                 (reset),
   .rsp_valid             (rsp_valid),
   .rsp_ready             (rsp_ready),
   .rsp_event_valid       (rsp_event_valid),
   .rsp_event_context     (rsp_event_context),
   .rsp_event_delay       (rsp_event_delay),
   .rsp_dropped           (rsp_dropped),
   .rsp_busy_count        (rsp_busy_count),
   .rsp_waiting_count_out (rsp_waiting_count_out),
   .rsp_max_waiting_out   (rsp_max_waiting_out)
);

// ===== dv/core_pool_scheduler_test.sv =====
module core_pool_scheduler_test;

   typedef struct packed {
      logic [cps_pkg::CMD_W-1:0]  command;
      logic [cps_pkg::CTX_W-1:0]  context_id;
      logic [cps_pkg::TIME_W-1:0] delay_ticks;
      logic                       core_continue;
      logic [cps_pkg::TIME_W-1:0] now_ticks;
   } sched_item_type;

   typedef struct packed {
      logic                       event_valid;
      logic [cps_pkg::CTX_W-1:0]  event_context;
      logic [cps_pkg::TIME_W-1:0] event_delay;
      logic                       dropped;
      logic [cps_pkg::CNT_W-1:0]  busy_count;
      logic [cps_pkg::CNT_W-1:0]  waiting_count;
      logic [cps_pkg::CNT_W-1:0]  max_waiting;
      logic [cps_pkg::AREA_W-1:0] busy_area;
      logic [cps_pkg::AREA_W-1:0] queue_area;
   } sched_status_type;

   typedef struct packed {
      logic [cps_pkg::CSR_IDX_W-1:0]  index;
      logic [cps_pkg::CSR_DATA_W-1:0] data;
   } reg_write_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                           req_valid = 1'b0;
   logic                           req_ready;
   logic [cps_pkg::CMD_W-1:0]      req_command = cps_pkg::CMD_NOP;
   logic [cps_pkg::CTX_W-1:0]      req_context_id = '0;
   logic [cps_pkg::TIME_W-1:0]     req_delay_ticks = '0;
   logic                           req_core_continue = 1'b0;
   logic [cps_pkg::TIME_W-1:0]     req_now_ticks = '0;

   logic                           rsp_valid;
   logic                           rsp_ready = 1'b0;
   logic                           rsp_event_valid;
   logic [cps_pkg::CTX_W-1:0]      rsp_event_context;
   logic [cps_pkg::TIME_W-1:0]     rsp_event_delay;
   logic                           rsp_dropped;
   logic [cps_pkg::CNT_W-1:0]      rsp_busy_count;
   logic [cps_pkg::CNT_W-1:0]      rsp_waiting_count_out;
   logic [cps_pkg::CNT_W-1:0]      rsp_max_waiting_out;
   logic [cps_pkg::AREA_W-1:0]     rsp_busy_area_out;
   logic [cps_pkg::AREA_W-1:0]     rsp_queue_area_out;

   logic                           csr_valid = 1'b0;
   logic                           csr_ready;
   logic [cps_pkg::CSR_IDX_W-1:0]  csr_index = cps_pkg::CSR_CORE_LIMIT;
   logic [cps_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   core_pool_scheduler dut (.*);

   // Predictor state: the pool, the waiting store, the statistics and the registers.
   logic [cps_pkg::CNT_W-1:0]  cfg_limit;
   logic [cps_pkg::OVH_W-1:0]  cfg_overhead;
   logic [cps_pkg::CNT_W-1:0]  pool_busy;
   logic [cps_pkg::CNT_W-1:0]  pool_prev_busy;
   logic [cps_pkg::CTX_W-1:0]  park_ctx [cps_pkg::STORE_DEPTH];
   logic [cps_pkg::TIME_W-1:0] park_dly [cps_pkg::STORE_DEPTH];
   logic [cps_pkg::CNT_W-1:0]  park_count;
   logic [cps_pkg::CNT_W-1:0]  park_peak;
   logic [cps_pkg::TIME_W-1:0] stat_time;
   logic [cps_pkg::AREA_W-1:0] busy_acc;
   logic [cps_pkg::AREA_W-1:0] queue_acc;

   sched_item_type   item_backlog [$];
   sched_status_type status_due [$];
   reg_write_type    reg_writes_due [$];

   sched_item_type   next_item;
   reg_write_type    next_write;
   sched_status_type want;
   int               gap_left = 0;
   int               burst_left = 1;
   int               stall_mode = 0;
   logic [31:0]      stall_tick = '0;
   logic [31:0]      sim_ticks = '0;
   int               items_loaded = 0;
   int               results_seen = 0;
   int               writes_queued = 0;
   int               writes_done = 0;
   int               failures = 0;

   initial forever #4 clock = ~clock;

   function automatic logic [cps_pkg::TIME_W-1:0] with_overhead(
         input logic [cps_pkg::TIME_W-1:0] d);
      logic [cps_pkg::TIME_W:0] s;
      s = {1'b0, d} + (cps_pkg::TIME_W+1)'(cfg_overhead);
      return s[cps_pkg::TIME_W] ? cps_pkg::DELAY_MAX : s[cps_pkg::TIME_W-1:0];
   endfunction

   function automatic logic [cps_pkg::AREA_W-1:0] grow_area(
         input logic [cps_pkg::AREA_W-1:0] acc,
         input logic [cps_pkg::CNT_W-1:0] n,
         input logic [cps_pkg::TIME_W-1:0] dt);
      logic [cps_pkg::AREA_W:0] s;
      s = {1'b0, acc} + (cps_pkg::AREA_W+1)'(n) * (cps_pkg::AREA_W+1)'(dt);
      return (s > {1'b0, cps_pkg::AREA_MAX}) ? cps_pkg::AREA_MAX : s[cps_pkg::AREA_W-1:0];
   endfunction

   function automatic void clear_pool();
      pool_busy = '0;
      pool_prev_busy = '0;
      park_count = '0;
      park_peak = '0;
      stat_time = '0;
      busy_acc = '0;
      queue_acc = '0;
   endfunction

   function automatic sched_status_type schedule_item(input sched_item_type it);
      sched_status_type r;
      logic [cps_pkg::CNT_W-1:0] limit;
      logic [cps_pkg::TIME_W-1:0] dt;
      r = '0;
      limit = (cfg_limit < cps_pkg::MAX_CORES) ? cfg_limit
                                               : cps_pkg::CNT_W'(cps_pkg::MAX_CORES);
      case (it.command)
         cps_pkg::CMD_REQUEST: begin
            if (it.core_continue) begin
               r.event_valid = 1'b1;
               r.event_context = it.context_id;
               r.event_delay = it.delay_ticks;
            end else if (pool_busy < limit) begin
               pool_busy = pool_busy + 1'b1;
               r.event_valid = 1'b1;
               r.event_context = it.context_id;
               r.event_delay = with_overhead(it.delay_ticks);
            end else if (park_count < cps_pkg::STORE_DEPTH) begin
               park_ctx[park_count[cps_pkg::ADDR_W-1:0]] = it.context_id;
               park_dly[park_count[cps_pkg::ADDR_W-1:0]] = it.delay_ticks;
               park_count = park_count + 1'b1;
               if (park_count > park_peak) park_peak = park_count;
            end else begin
               r.dropped = 1'b1;
            end
         end
         cps_pkg::CMD_RELEASE: begin
            if (park_count == 0) begin
               if (pool_busy > 0) pool_busy = pool_busy - 1'b1;
            end else begin
               park_count = park_count - 1'b1;
               r.event_valid = 1'b1;
               r.event_context = park_ctx[park_count[cps_pkg::ADDR_W-1:0]];
               r.event_delay = with_overhead(park_dly[park_count[cps_pkg::ADDR_W-1:0]]);
            end
            dt = (it.now_ticks >= stat_time) ? it.now_ticks - stat_time : '0;
            busy_acc = grow_area(busy_acc, pool_prev_busy, dt);
            queue_acc = grow_area(queue_acc, park_count, dt);
            stat_time = it.now_ticks;
            pool_prev_busy = pool_busy;
         end
         cps_pkg::CMD_CLEAR: clear_pool();
         default: ;
      endcase
      r.busy_count = pool_busy;
      r.waiting_count = park_count;
      r.max_waiting = park_peak;
      r.busy_area = busy_acc;
      r.queue_area = queue_acc;
      return r;
   endfunction

   task automatic check_field(input string name, input logic [cps_pkg::AREA_W-1:0] got,
                              input logic [cps_pkg::AREA_W-1:0] exp_val);
      if (got !== exp_val) begin
         failures++;
         if (failures <= 10)
            $display("item %0d: %s expected %0h, got %0h", results_seen, name, exp_val, got);
      end
   endtask

   task automatic post(input logic [cps_pkg::CMD_W-1:0] cmd,
                       input logic [cps_pkg::CTX_W-1:0] ctx,
                       input logic [cps_pkg::TIME_W-1:0] dly, input logic cont,
                       input logic [cps_pkg::TIME_W-1:0] now);
      sched_item_type it;
      it.command = cmd;
      it.context_id = ctx;
      it.delay_ticks = dly;
      it.core_continue = cont;
      it.now_ticks = now;
      item_backlog = {item_backlog, it};
      items_loaded++;
   endtask

   task automatic post_random(input int req_pct);
      int pick;
      logic [cps_pkg::CMD_W-1:0] cmd;
      logic [cps_pkg::TIME_W-1:0] dly;
      logic [cps_pkg::TIME_W-1:0] now;
      pick = $urandom_range(0, 99);
      if (pick < req_pct) cmd = cps_pkg::CMD_REQUEST;
      else if (pick < 94) cmd = cps_pkg::CMD_RELEASE;
      else if (pick < 97) cmd = cps_pkg::CMD_NOP;
      else cmd = cps_pkg::CMD_CLEAR;
      case ($urandom_range(0, 3))
         0: dly = $urandom_range(0, 1000);
         1: dly = cps_pkg::DELAY_MAX - $urandom_range(0, 70000);
         default: dly = $urandom;
      endcase
      if ($urandom_range(0, 9) == 0) begin
         now = $urandom;
      end else begin
         sim_ticks = sim_ticks + $urandom_range(0, 5000);
         now = sim_ticks;
      end
      post(cmd, cps_pkg::CTX_W'($urandom), dly, $urandom_range(0, 4) == 0, now);
   endtask

   task automatic write_reg(input logic [cps_pkg::CSR_IDX_W-1:0] idx,
                            input logic [cps_pkg::CSR_DATA_W-1:0] val);
      reg_write_type w;
      w.index = idx;
      w.data = val;
      @(negedge clock);
      reg_writes_due = {reg_writes_due, w};
      writes_queued++;
      while (writes_done != writes_queued) @(negedge clock);
   endtask

   task automatic settle();
      while (results_seen < items_loaded) @(negedge clock);
      repeat (6) @(negedge clock);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         clear_pool();
      end else begin
         if (req_valid && req_ready) begin
            next_item.command = req_command;
            next_item.context_id = req_context_id;
            next_item.delay_ticks = req_delay_ticks;
            next_item.core_continue = req_core_continue;
            next_item.now_ticks = req_now_ticks;
            status_due = {status_due, schedule_item(next_item)};
         end
         if (!req_valid || req_ready) begin
            if (gap_left > 0 || item_backlog.size() == 0) begin
               if (gap_left > 0) gap_left--;
               req_valid <= 1'b0;
            end else begin
               next_item = item_backlog.pop_front();
               req_valid <= 1'b1;
               req_command <= next_item.command;
               req_context_id <= next_item.context_id;
               req_delay_ticks <= next_item.delay_ticks;
               req_core_continue <= next_item.core_continue;
               req_now_ticks <= next_item.now_ticks;
               burst_left--;
               if (burst_left <= 0) begin
                  burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
                                                           : $urandom_range(1, 8);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         csr_valid <= 1'b0;
         cfg_limit = 5'd1;
         cfg_overhead = '0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               cps_pkg::CSR_CORE_LIMIT: cfg_limit = csr_wdata[cps_pkg::CNT_W-1:0];
               cps_pkg::CSR_OVERHEAD:   cfg_overhead = csr_wdata;
               default: ;
            endcase
            writes_done++;
         end
         if (!csr_valid || csr_ready) begin
            if (reg_writes_due.size() > 0) begin
               next_write = reg_writes_due.pop_front();
               csr_valid <= 1'b1;
               csr_index <= next_write.index;
               csr_wdata <= next_write.data;
            end else begin
               csr_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            results_seen++;
            if (status_due.size() == 0) begin
               failures++;
               if (failures <= 10)
                  $display("item %0d: result arrived with no item outstanding", results_seen);
            end else begin
               want = status_due.pop_front();
               check_field("event_valid", cps_pkg::AREA_W'(rsp_event_valid),
                           cps_pkg::AREA_W'(want.event_valid));
               check_field("event_context", cps_pkg::AREA_W'(rsp_event_context),
                           cps_pkg::AREA_W'(want.event_context));
               check_field("event_delay", cps_pkg::AREA_W'(rsp_event_delay),
                           cps_pkg::AREA_W'(want.event_delay));
               check_field("dropped", cps_pkg::AREA_W'(rsp_dropped),
                           cps_pkg::AREA_W'(want.dropped));
               check_field("busy_count", cps_pkg::AREA_W'(rsp_busy_count),
                           cps_pkg::AREA_W'(want.busy_count));
               check_field("waiting_count_out", cps_pkg::AREA_W'(rsp_waiting_count_out),
                           cps_pkg::AREA_W'(want.waiting_count));
               check_field("max_waiting_out", cps_pkg::AREA_W'(rsp_max_waiting_out),
                           cps_pkg::AREA_W'(want.max_waiting));
               check_field("busy_area_out", rsp_busy_area_out, want.busy_area);
               check_field("queue_area_out", rsp_queue_area_out, want.queue_area);
            end
         end
         stall_tick <= stall_tick + 1;
         if (stall_tick[5:0] == 0) stall_mode = $urandom_range(0, 3);
         case (stall_mode)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= $urandom_range(0, 1) == 1;
            2: rsp_ready <= $urandom_range(0, 3) == 0;
            default: rsp_ready <= stall_tick[2];
         endcase
      end
   end

   initial begin
      #20000000;
      $display("FAIL");
      $finish;
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      write_reg(cps_pkg::CSR_CORE_LIMIT, 16'd2);
      write_reg(cps_pkg::CSR_OVERHEAD, 16'hFFFF);
      post(cps_pkg::CMD_REQUEST, 16'hFFFF, cps_pkg::DELAY_MAX, 1'b1, 32'd0);
      post(cps_pkg::CMD_REQUEST, 16'h0000, 32'd0, 1'b1, 32'd0);
      post(cps_pkg::CMD_REQUEST, 16'h1234, cps_pkg::DELAY_MAX, 1'b0, 32'd0);
      post(cps_pkg::CMD_REQUEST, 16'h0000, 32'd0, 1'b0, 32'd0);
      for (int i = 0; i < cps_pkg::STORE_DEPTH; i++)
         post(cps_pkg::CMD_REQUEST,
              i[0] ? 16'hFFFF - cps_pkg::CTX_W'(i) : cps_pkg::CTX_W'(i),
              i[0] ? 32'hFFFF_FFF0 + cps_pkg::TIME_W'(i) : cps_pkg::TIME_W'(i),
              1'b0, 32'd0);
      post(cps_pkg::CMD_REQUEST, 16'hBEEF, 32'hDEAD_BEEF, 1'b0, 32'd0);
      post(cps_pkg::CMD_RELEASE, 16'h0000, 32'd0, 1'b0, 32'd1000);
      post(cps_pkg::CMD_RELEASE, 16'h0000, 32'd0, 1'b0, 32'd500);
      post(cps_pkg::CMD_RELEASE, 16'h0000, 32'd0, 1'b0, 32'd70000);
      post(cps_pkg::CMD_NOP, 16'hFFFF, cps_pkg::DELAY_MAX, 1'b1, cps_pkg::DELAY_MAX);
      post(cps_pkg::CMD_CLEAR, 16'h0000, 32'd0, 1'b0, 32'd0);
      post(cps_pkg::CMD_RELEASE, 16'h0000, 32'd0, 1'b0, cps_pkg::DELAY_MAX);
      settle();

      // Keep a full pool and a full store while time swings between zero and its
      // maximum.
      write_reg(cps_pkg::CSR_CORE_LIMIT, 16'd16);
      write_reg(cps_pkg::CSR_OVERHEAD, cps_pkg::CSR_DATA_W'($urandom));
      post(cps_pkg::CMD_CLEAR, 16'h0000, 32'd0, 1'b0, 32'd0);
      for (int i = 0; i < 2 * cps_pkg::STORE_DEPTH; i++)
         post(cps_pkg::CMD_REQUEST, cps_pkg::CTX_W'($urandom), $urandom, 1'b0, 32'd0);
      for (int i = 0; i < 40; i++) begin
         post(cps_pkg::CMD_RELEASE, cps_pkg::CTX_W'($urandom), $urandom, 1'b0,
              cps_pkg::DELAY_MAX);
         post(cps_pkg::CMD_REQUEST, cps_pkg::CTX_W'($urandom), $urandom, 1'b0, $urandom);
         post(cps_pkg::CMD_RELEASE, cps_pkg::CTX_W'($urandom), $urandom, 1'b0, 32'd0);
         post(cps_pkg::CMD_REQUEST, cps_pkg::CTX_W'($urandom), $urandom, 1'b0, $urandom);
      end
      settle();

      for (int p = 0; p < 4; p++) begin
         case (p)
            0: begin
               write_reg(cps_pkg::CSR_CORE_LIMIT, 16'd1);
               write_reg(cps_pkg::CSR_OVERHEAD, 16'd0);
            end
            1: begin
               write_reg(cps_pkg::CSR_CORE_LIMIT, 16'd16);
               write_reg(cps_pkg::CSR_OVERHEAD, 16'hFFFF);
            end
            2: begin
               write_reg(cps_pkg::CSR_CORE_LIMIT, 16'd3);
               write_reg(cps_pkg::CSR_OVERHEAD, cps_pkg::CSR_DATA_W'($urandom));
            end
            default: begin
               write_reg(cps_pkg::CSR_CORE_LIMIT,
                         cps_pkg::CSR_DATA_W'($urandom_range(1, 16)));
               write_reg(cps_pkg::CSR_OVERHEAD, cps_pkg::CSR_DATA_W'($urandom));
            end
         endcase
         repeat (50) post_random(45 + 5 * p);
         settle();
         repeat (50) post_random(45 + 5 * p);
         settle();
      end

      if (failures == 0 && status_due.size() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

// ===== core_pool_scheduler.f =====
hw/rtl/cps_pkg.sv
hw/rtl/cps_store.sv
hw/rtl/cps_area.sv
hw/rtl/core_pool_scheduler.sv
hw/rtl/cps_checker.sv
dv/core_pool_scheduler_test.sv
